### rtl/core/decaying_sine_tone_generator_core_assert.svh
// Assertion macros used by the tone generator back end.
`ifndef DECAYING_SINE_TONE_GENERATOR_CORE_ASSERT_SVH
`define DECAYING_SINE_TONE_GENERATOR_CORE_ASSERT_SVH

// A property that must hold at every rising edge outside reset.
`define DSTG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dstg assertion failed");

// A condition that must hold in the cycle after the trigger.
`define DSTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dstg assertion failed");

`endif

### rtl/core/dstg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dstg_pkg;

  localparam int PHASE_BITS           = 32;
  localparam int SINE_TABLE_DEPTH     = 1024;
  localparam int ENVELOPE_TABLE_DEPTH = 256;
  localparam int COUNT_BITS           = 24;

  localparam int RATE_BITS     = 18;
  localparam int FREQ_BITS     = 16;
  localparam int LEN_BITS      = 16;
  localparam int AMP_BITS      = 15;
  localparam int SAMPLE_BITS   = 16;
  localparam int ENV_BITS      = 16;
  localparam int ENV_ACC_BITS  = 32;
  localparam int Q15_SHIFT     = 15;
  localparam int SINE_MAG_BITS = 15;
  localparam int MS_PER_S      = 1000;

  localparam logic [RATE_BITS-1:0] RATE_RESET = 18'd44100;

  localparam int PROD_BITS  = RATE_BITS + LEN_BITS;
  localparam int CYCLE_BITS = FREQ_BITS + LEN_BITS - 9;
  localparam int DIV_A      = (PROD_BITS > COUNT_BITS + PHASE_BITS) ?
                              PROD_BITS : COUNT_BITS + PHASE_BITS;
  localparam int DIV_BITS   = (DIV_A > ENV_ACC_BITS + 1) ? DIV_A : ENV_ACC_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

  localparam logic [DIV_BITS-1:0] ENV_FULL_SCALE =
    {{(DIV_BITS - ENV_ACC_BITS - 1){1'b0}}, 1'b1, {ENV_ACC_BITS{1'b0}}};

  // Division by 1000 is a shift by 3 and a multiply by the rounded-up reciprocal of 125,
  // which is exact for every product that fits in PROD_BITS.
  localparam int MS_POW2_SHIFT = 3;
  localparam int MS_ODD_FACTOR = MS_PER_S >> MS_POW2_SHIFT;
  localparam int MS_Y_BITS     = PROD_BITS - MS_POW2_SHIFT;
  localparam int MS_RCP_BITS   = 32;
  localparam int MS_RCP_SHIFT  = MS_Y_BITS + $clog2(MS_ODD_FACTOR);
  localparam int MS_PROD_BITS  = MS_Y_BITS + MS_RCP_BITS;
  localparam int MS_QUO_BITS   = MS_PROD_BITS - MS_RCP_SHIFT;
  localparam logic [MS_RCP_BITS-1:0] MS_RCP =
    MS_RCP_BITS'(((64'd1 << MS_RCP_SHIFT) + 64'(MS_ODD_FACTOR) - 64'd1) /
                 64'(MS_ODD_FACTOR));

  localparam int SINE_IDX_BITS     = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QUARTER      = SINE_TABLE_DEPTH / 4;
  localparam int SINE_QUARTER_BITS = $clog2(SINE_QUARTER);
  localparam int ENV_IDX_BITS      = $clog2(ENVELOPE_TABLE_DEPTH);

  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int CMD_PTR_BITS    = $clog2(CMD_QUEUE_DEPTH);
  localparam int CMD_CNT_BITS    = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam int OUT_QUEUE_DEPTH = 2;
  localparam int OUT_PTR_BITS    = $clog2(OUT_QUEUE_DEPTH);
  localparam int OUT_CNT_BITS    = $clog2(OUT_QUEUE_DEPTH + 1);

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = (64'd31415926 << 30) / 64'd10000000;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [FREQ_BITS-1:0] tone_frequency;
    logic [LEN_BITS-1:0]  length_ms;
    logic [AMP_BITS-1:0]  peak_amplitude;
    logic                 use_decay;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_BITS-1:0]   quotient;
    logic [COUNT_BITS-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_N,
    BK_RCP_N,
    BK_MUL_C,
    BK_RCP_C,
    BK_MOD,
    BK_DIV_P,
    BK_DIV_E,
    BK_LOAD,
    BK_TICK_LOOK,
    BK_TICK_AMP,
    BK_TICK_OUT
  } back_state_t;

  typedef logic [SINE_MAG_BITS-1:0] sine_quarter_t [SINE_QUARTER + 1];
  typedef logic [ENV_BITS-1:0] env_rom_t [ENVELOPE_TABLE_DEPTH];

  // Magnitude of the first quadrant, evaluated with a Q30 Taylor series.
  function automatic sine_quarter_t build_sine_quarter();
    sine_quarter_t     rom;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    for (int j = 0; j <= SINE_QUARTER; j++) begin
      x = ((PI_Q30 / 64'd2) * 64'(4 * j)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      sum = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        mag = 64'd0;
      end else begin
        mag = ((64'(sum) * 64'd32768) + (ONE_Q30 >> 1)) >> 30;
      end
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      rom[j] = SINE_MAG_BITS'(mag);
    end
    return rom;
  endfunction

  // Decay envelope exp(-2x), built from exp(-x/2) squared twice.
  function automatic env_rom_t build_env_rom();
    env_rom_t           rom;
    logic [63:0]        z;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int k = 0; k < ENVELOPE_TABLE_DEPTH; k++) begin
      z = (64'(k) << 29) / 64'(ENVELOPE_TABLE_DEPTH);
      term = ONE_Q30;
      sum = $signed(ONE_Q30);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * z) >> 30) / 64'(n);
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      e = (sum < 0) ? 64'd0 : 64'(sum);
      e = (e * e) >> 30;
      e = (e * e) >> 30;
      v = ((e * 64'd32768) + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      rom[k] = ENV_BITS'(v);
    end
    return rom;
  endfunction

  localparam sine_quarter_t SINE_QUARTER_ROM = build_sine_quarter();
  localparam env_rom_t      ENV_ROM          = build_env_rom();

endpackage
`default_nettype wire

### rtl/core/dstg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dstg_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_func,
  input  logic [dstg_pkg::FREQ_BITS-1:0]    in_tone_frequency,
  input  logic [dstg_pkg::LEN_BITS-1:0]     in_length_ms,
  input  logic [dstg_pkg::AMP_BITS-1:0]     in_peak_amplitude,
  input  logic                              in_use_decay,
  output logic                              cmd_valid,
  output dstg_pkg::cmd_t                    cmd,
  input  logic                              cmd_pop
);

  dstg_pkg::cmd_t                         entries_r [dstg_pkg::CMD_QUEUE_DEPTH];
  dstg_pkg::cmd_t                         cmd_in;
  logic [dstg_pkg::CMD_PTR_BITS-1:0]      wr_ptr_r;
  logic [dstg_pkg::CMD_PTR_BITS-1:0]      wr_ptr_nxt;
  logic [dstg_pkg::CMD_PTR_BITS-1:0]      rd_ptr_r;
  logic [dstg_pkg::CMD_PTR_BITS-1:0]      rd_ptr_nxt;
  logic [dstg_pkg::CMD_CNT_BITS-1:0]      count_r;
  logic [dstg_pkg::CMD_CNT_BITS-1:0]      count_nxt;
  logic                                   push_ok;
  logic                                   pop_ok;

  always_comb begin
    cmd_in.op             = in_func ? dstg_pkg::OP_TICK : dstg_pkg::OP_START;
    cmd_in.tone_frequency = in_tone_frequency;
    cmd_in.length_ms      = in_length_ms;
    cmd_in.peak_amplitude = in_peak_amplitude;
    cmd_in.use_decay      = in_use_decay;
  end

  assign in_full   = (count_r == dstg_pkg::CMD_CNT_BITS'(dstg_pkg::CMD_QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = entries_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

### rtl/core/dstg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module dstg_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dstg_pkg::div_req_t   div_req,
  output dstg_pkg::div_rsp_t   div_rsp
);

  logic                                  busy_r;
  logic                                  busy_nxt;
  logic                                  done_r;
  logic                                  done_nxt;
  logic [dstg_pkg::DIV_CNT_BITS-1:0]     cnt_r;
  logic [dstg_pkg::DIV_CNT_BITS-1:0]     cnt_nxt;
  logic [dstg_pkg::DIV_BITS-1:0]         quo_r;
  logic [dstg_pkg::DIV_BITS-1:0]         quo_nxt;
  logic [dstg_pkg::COUNT_BITS-1:0]       rem_r;
  logic [dstg_pkg::COUNT_BITS-1:0]       rem_nxt;
  logic [dstg_pkg::COUNT_BITS-1:0]       dvs_r;
  logic [dstg_pkg::COUNT_BITS-1:0]       dvs_nxt;
  logic [dstg_pkg::COUNT_BITS:0]         shifted;
  logic [dstg_pkg::COUNT_BITS:0]         diff;
  logic                                  q_bit;

  // One quotient bit per cycle, restoring.
  always_comb begin
    shifted = {rem_r, quo_r[dstg_pkg::DIV_BITS-1]};
    diff    = shifted - {1'b0, dvs_r};
    q_bit   = (shifted >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (div_req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = dstg_pkg::DIV_CNT_BITS'(dstg_pkg::DIV_BITS);
      quo_nxt  = div_req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = div_req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[dstg_pkg::DIV_BITS-2:0], q_bit};
      rem_nxt = q_bit ? diff[dstg_pkg::COUNT_BITS-1:0] : shifted[dstg_pkg::COUNT_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dstg_pkg::DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    div_rsp.busy      = busy_r;
    div_rsp.done      = done_r;
    div_rsp.quotient  = quo_r;
    div_rsp.remainder = rem_r;
  end

endmodule
`default_nettype wire

### rtl/core/dstg_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module dstg_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_push,
  input  dstg_pkg::result_t    res_data,
  output logic                 res_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output dstg_pkg::result_t    out_data
);

  dstg_pkg::result_t                      entries_r [dstg_pkg::OUT_QUEUE_DEPTH];
  logic [dstg_pkg::OUT_PTR_BITS-1:0]      wr_ptr_r;
  logic [dstg_pkg::OUT_PTR_BITS-1:0]      wr_ptr_nxt;
  logic [dstg_pkg::OUT_PTR_BITS-1:0]      rd_ptr_r;
  logic [dstg_pkg::OUT_PTR_BITS-1:0]      rd_ptr_nxt;
  logic [dstg_pkg::OUT_CNT_BITS-1:0]      count_r;
  logic [dstg_pkg::OUT_CNT_BITS-1:0]      count_nxt;
  logic                                   push_ok;
  logic                                   pop_ok;

  assign res_full  = (count_r == dstg_pkg::OUT_CNT_BITS'(dstg_pkg::OUT_QUEUE_DEPTH));
  assign out_empty = (count_r == '0);
  assign out_data  = entries_r[rd_ptr_r];
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries_r[wr_ptr_r] <= res_data;
    end
  end

endmodule
`default_nettype wire

### rtl/core/dstg_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "decaying_sine_tone_generator_core_assert.svh"
module dstg_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [dstg_pkg::RATE_BITS-1:0]    cfg_sample_rate_hz,
  input  logic                              cmd_valid,
  input  dstg_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  output dstg_pkg::div_req_t                div_req,
  input  dstg_pkg::div_rsp_t                div_rsp,
  input  logic                              out_full,
  output logic                              out_push,
  output dstg_pkg::result_t                 out_data
);

  typedef struct packed {
    logic [dstg_pkg::PHASE_BITS-1:0]   phase_acc;
    logic [dstg_pkg::PHASE_BITS-1:0]   phase_inc;
    logic [dstg_pkg::ENV_ACC_BITS-1:0] env_acc;
    logic [dstg_pkg::ENV_ACC_BITS-1:0] env_inc;
    logic [dstg_pkg::COUNT_BITS-1:0]   remaining;
    logic [dstg_pkg::AMP_BITS-1:0]     amp;
    logic                              decay;
  } note_t;

  typedef struct packed {
    logic [dstg_pkg::PROD_BITS-1:0]    prod;
    logic [dstg_pkg::COUNT_BITS-1:0]   n;
    logic [dstg_pkg::CYCLE_BITS-1:0]   cycles;
    logic [dstg_pkg::COUNT_BITS-1:0]   rem;
    logic [dstg_pkg::PHASE_BITS-1:0]   pinc;
    logic [dstg_pkg::ENV_ACC_BITS-1:0] einc;
  } calc_t;

  typedef struct packed {
    logic [dstg_pkg::SINE_MAG_BITS-1:0] smag;
    logic                               sneg;
    logic [dstg_pkg::ENV_BITS-1:0]      env;
    logic [dstg_pkg::AMP_BITS-1:0]      amp;
  } tick_t;

  dstg_pkg::back_state_t                        state_r;
  dstg_pkg::back_state_t                        state_nxt;
  logic [dstg_pkg::RATE_BITS-1:0]               rate_r;
  logic [dstg_pkg::RATE_BITS-1:0]               rate_nxt;
  note_t                                        note_r;
  note_t                                        note_nxt;
  calc_t                                        calc_r;
  calc_t                                        calc_nxt;
  tick_t                                        tick_r;
  tick_t                                        tick_nxt;
  logic                                         div_started_r;
  logic                                         div_started_nxt;
  logic                                         div_state;
  logic                                         div_done;
  logic [dstg_pkg::SINE_IDX_BITS-1:0]           sidx;
  logic [1:0]                                   quad;
  logic [dstg_pkg::SINE_QUARTER_BITS-1:0]       qlow;
  logic [dstg_pkg::SINE_QUARTER_BITS:0]         qidx;
  logic [dstg_pkg::ENV_IDX_BITS-1:0]            eidx;
  logic [dstg_pkg::AMP_BITS+dstg_pkg::ENV_BITS-1:0]       amp_prod;
  logic [dstg_pkg::AMP_BITS+dstg_pkg::SINE_MAG_BITS-1:0]  mag_prod;
  logic [dstg_pkg::SAMPLE_BITS-1:0]             mag_ext;
  logic [dstg_pkg::MS_PROD_BITS-1:0]            ms_prod;
  logic [dstg_pkg::MS_QUO_BITS-1:0]             ms_quo;

  assign div_state = (state_r == dstg_pkg::BK_MOD) || (state_r == dstg_pkg::BK_DIV_P) ||
                     (state_r == dstg_pkg::BK_DIV_E);
  assign div_done  = div_started_r && div_rsp.done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dstg_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == dstg_pkg::OP_START) begin
            state_nxt = dstg_pkg::BK_MUL_N;
          end else if (note_r.remaining != '0) begin
            state_nxt = dstg_pkg::BK_TICK_LOOK;
          end
        end
      end
      dstg_pkg::BK_MUL_N: state_nxt = dstg_pkg::BK_RCP_N;
      dstg_pkg::BK_RCP_N: state_nxt = dstg_pkg::BK_MUL_C;
      dstg_pkg::BK_MUL_C: state_nxt = dstg_pkg::BK_RCP_C;
      dstg_pkg::BK_RCP_C: begin
        state_nxt = (calc_r.n == '0) ? dstg_pkg::BK_LOAD : dstg_pkg::BK_MOD;
      end
      dstg_pkg::BK_MOD: begin
        if (div_done) begin
          state_nxt = dstg_pkg::BK_DIV_P;
        end
      end
      dstg_pkg::BK_DIV_P: begin
        if (div_done) begin
          state_nxt = dstg_pkg::BK_DIV_E;
        end
      end
      dstg_pkg::BK_DIV_E: begin
        if (div_done) begin
          state_nxt = dstg_pkg::BK_LOAD;
        end
      end
      dstg_pkg::BK_LOAD:      state_nxt = dstg_pkg::BK_IDLE;
      dstg_pkg::BK_TICK_LOOK: state_nxt = dstg_pkg::BK_TICK_AMP;
      dstg_pkg::BK_TICK_AMP:  state_nxt = dstg_pkg::BK_TICK_OUT;
      dstg_pkg::BK_TICK_OUT: begin
        if (!out_full) begin
          state_nxt = dstg_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dstg_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    sidx = note_r.phase_acc[dstg_pkg::PHASE_BITS-1 -: dstg_pkg::SINE_IDX_BITS];
    quad = sidx[dstg_pkg::SINE_IDX_BITS-1 -: 2];
    qlow = sidx[dstg_pkg::SINE_QUARTER_BITS-1:0];
    qidx = quad[0] ?
           (dstg_pkg::SINE_QUARTER_BITS + 1)'(dstg_pkg::SINE_QUARTER) - {1'b0, qlow} :
           {1'b0, qlow};
    eidx = note_r.env_acc[dstg_pkg::ENV_ACC_BITS-1 -: dstg_pkg::ENV_IDX_BITS];
    amp_prod = (dstg_pkg::AMP_BITS + dstg_pkg::ENV_BITS)'(note_r.amp) *
               (dstg_pkg::AMP_BITS + dstg_pkg::ENV_BITS)'(tick_r.env);
    mag_prod = (dstg_pkg::AMP_BITS + dstg_pkg::SINE_MAG_BITS)'(tick_r.amp) *
               (dstg_pkg::AMP_BITS + dstg_pkg::SINE_MAG_BITS)'(tick_r.smag);
    mag_ext  = dstg_pkg::SAMPLE_BITS'(
                 mag_prod[dstg_pkg::Q15_SHIFT + dstg_pkg::AMP_BITS - 1 : dstg_pkg::Q15_SHIFT]);
    ms_prod  = dstg_pkg::MS_PROD_BITS'(
                 calc_r.prod[dstg_pkg::PROD_BITS-1:dstg_pkg::MS_POW2_SHIFT]) *
               dstg_pkg::MS_PROD_BITS'(dstg_pkg::MS_RCP);
    ms_quo   = ms_prod[dstg_pkg::MS_PROD_BITS-1:dstg_pkg::MS_RCP_SHIFT];
  end

  always_comb begin
    rate_nxt        = rate_r;
    note_nxt        = note_r;
    calc_nxt        = calc_r;
    tick_nxt        = tick_r;
    div_started_nxt = div_started_r;
    cmd_pop         = 1'b0;
    out_push        = 1'b0;
    out_data.sample = tick_r.sneg ? $signed(-mag_ext) : $signed(mag_ext);
    out_data.last_sample = (note_r.remaining == '0);

    div_req.start    = div_state && !div_started_r;
    div_req.dividend = dstg_pkg::DIV_BITS'(calc_r.cycles);
    div_req.divisor  = calc_r.n;
    case (state_r)
      dstg_pkg::BK_DIV_P: begin
        div_req.dividend = dstg_pkg::DIV_BITS'({calc_r.rem, {dstg_pkg::PHASE_BITS{1'b0}}});
      end
      dstg_pkg::BK_DIV_E: begin
        div_req.dividend = dstg_pkg::ENV_FULL_SCALE;
      end
      default: begin
      end
    endcase

    if (div_req.start) begin
      div_started_nxt = 1'b1;
    end else if (div_done) begin
      div_started_nxt = 1'b0;
    end

    if (cfg_valid) begin
      rate_nxt = cfg_sample_rate_hz;
    end

    case (state_r)
      dstg_pkg::BK_IDLE: begin
        if (cmd_valid && (cmd.op == dstg_pkg::OP_TICK) && (note_r.remaining == '0)) begin
          cmd_pop = 1'b1;
        end
      end
      dstg_pkg::BK_MUL_N: begin
        calc_nxt.prod = dstg_pkg::PROD_BITS'(rate_r) * dstg_pkg::PROD_BITS'(cmd.length_ms);
      end
      dstg_pkg::BK_RCP_N: begin
        if (ms_quo[dstg_pkg::MS_QUO_BITS-1:dstg_pkg::COUNT_BITS] != '0) begin
          calc_nxt.n = '1;
        end else begin
          calc_nxt.n = ms_quo[dstg_pkg::COUNT_BITS-1:0];
        end
      end
      dstg_pkg::BK_MUL_C: begin
        calc_nxt.prod = dstg_pkg::PROD_BITS'(cmd.tone_frequency) *
                        dstg_pkg::PROD_BITS'(cmd.length_ms);
      end
      dstg_pkg::BK_RCP_C: begin
        calc_nxt.cycles = ms_quo[dstg_pkg::CYCLE_BITS-1:0];
        calc_nxt.pinc   = '0;
        calc_nxt.einc   = '0;
      end
      dstg_pkg::BK_MOD: begin
        if (div_done) begin
          calc_nxt.rem = div_rsp.remainder;
        end
      end
      dstg_pkg::BK_DIV_P: begin
        if (div_done) begin
          calc_nxt.pinc = div_rsp.quotient[dstg_pkg::PHASE_BITS-1:0];
        end
      end
      dstg_pkg::BK_DIV_E: begin
        if (div_done) begin
          if (div_rsp.quotient[dstg_pkg::DIV_BITS-1:dstg_pkg::ENV_ACC_BITS] != '0) begin
            calc_nxt.einc = '1;
          end else begin
            calc_nxt.einc = div_rsp.quotient[dstg_pkg::ENV_ACC_BITS-1:0];
          end
        end
      end
      dstg_pkg::BK_LOAD: begin
        note_nxt.phase_acc = '0;
        note_nxt.phase_inc = calc_r.pinc;
        note_nxt.env_acc   = '0;
        note_nxt.env_inc   = calc_r.einc;
        note_nxt.remaining = calc_r.n;
        note_nxt.amp       = cmd.peak_amplitude;
        note_nxt.decay     = cmd.use_decay;
        cmd_pop            = 1'b1;
      end
      dstg_pkg::BK_TICK_LOOK: begin
        tick_nxt.smag      = dstg_pkg::SINE_QUARTER_ROM[qidx];
        tick_nxt.sneg      = quad[1];
        tick_nxt.env       = dstg_pkg::ENV_ROM[eidx];
        note_nxt.phase_acc = note_r.phase_acc + note_r.phase_inc;
        note_nxt.env_acc   = note_r.env_acc + note_r.env_inc;
        note_nxt.remaining = note_r.remaining - 1'b1;
        cmd_pop            = 1'b1;
      end
      dstg_pkg::BK_TICK_AMP: begin
        if (note_r.decay) begin
          tick_nxt.amp = amp_prod[dstg_pkg::Q15_SHIFT + dstg_pkg::AMP_BITS - 1 :
                                  dstg_pkg::Q15_SHIFT];
        end else begin
          tick_nxt.amp = note_r.amp;
        end
      end
      dstg_pkg::BK_TICK_OUT: begin
        out_push = !out_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dstg_pkg::BK_IDLE;
      rate_r        <= dstg_pkg::RATE_RESET;
      note_r        <= '0;
      div_started_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rate_r        <= rate_nxt;
      note_r        <= note_nxt;
      div_started_r <= div_started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    calc_r <= calc_nxt;
    tick_r <= tick_nxt;
  end

  `DSTG_ASSERT(a_push_room, clk, rst_n, out_push |-> !out_full)
  `DSTG_ASSERT(a_div_start_idle, clk, rst_n, div_req.start |-> !div_rsp.busy)
  `DSTG_ASSERT(a_last_flag, clk, rst_n, out_push |-> (out_data.last_sample == (note_r.remaining == '0)))
  `DSTG_ASSERT_NEXT(a_count_down, clk, rst_n, state_r == dstg_pkg::BK_TICK_LOOK, (note_r.remaining + 1'b1) == $past(note_r.remaining))

endmodule
`default_nettype wire

### rtl/core/decaying_sine_tone_generator_core.sv
// Decaying sine tone generator.
// Input queue: an item is taken when in_push is high and in_full is low. A start item
// (in_func low) loads a note from the tone frequency, length, peak amplitude and decay
// flag; a tick item (in_func high) produces one sample while the note has samples left.
// Result queue: the oldest sample is on out_sample and out_last_sample while out_empty is
// low, and it is taken when out_pop is high. out_last_sample marks the note's final sample.
// Configuration: the sample rate is written when cfg_valid is high; cfg_ready is always high.
// A tick passes through the back end in order: dispatch, table lookup, envelope multiply and
// sample multiply, which waits while the result queue is full; the next item is taken only
// after the sample is pushed.
// A start item takes two reciprocal multiplies for the divisions by 1000 and three passes of
// the shared bit-serial divider; an empty note skips the divider passes.
// Ticks that find no note playing are dropped without a result.
// Reset sets the sample rate to 44100 Hz, clears the note state and empties both queues.
// When the receiver stalls, the 2-entry result queue fills, the back end holds its sample,
// the 4-entry input queue fills, and in_full rises; no item is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module decaying_sine_tone_generator_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic                                   in_func,
  input  logic [dstg_pkg::FREQ_BITS-1:0]         in_tone_frequency,
  input  logic [dstg_pkg::LEN_BITS-1:0]          in_length_ms,
  input  logic [dstg_pkg::AMP_BITS-1:0]          in_peak_amplitude,
  input  logic                                   in_use_decay,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [dstg_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                   out_last_sample,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dstg_pkg::RATE_BITS-1:0]         cfg_sample_rate_hz
);

  logic                  cmd_valid;
  dstg_pkg::cmd_t        cmd;
  logic                  cmd_pop;
  dstg_pkg::div_req_t    div_req;
  dstg_pkg::div_rsp_t    div_rsp;
  logic                  res_full;
  logic                  res_push;
  dstg_pkg::result_t     res_data;
  dstg_pkg::result_t     out_data;

  assign cfg_ready       = 1'b1;
  assign out_sample      = out_data.sample;
  assign out_last_sample = out_data.last_sample;

  dstg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_func           (in_func),
    .in_tone_frequency (in_tone_frequency),
    .in_length_ms      (in_length_ms),
    .in_peak_amplitude (in_peak_amplitude),
    .in_use_decay      (in_use_decay),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop)
  );

  dstg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  dstg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_sample_rate_hz (cfg_sample_rate_hz),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_full           (res_full),
    .out_push           (res_push),
    .out_data           (res_data)
  );

  dstg_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
